[rtl/msm_pkg.sv]
// Shared types, constants and the gain function for the sample mixer.
// No dependencies; imported by every module of the mixer.
`default_nettype none

package msm_pkg;

	localparam int NUM_VOICES  = 8;
	localparam int STORE_BYTES = 65536;

	localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SW      = $clog2(STORE_BYTES);
	localparam int SUM_W   = $clog2(NUM_VOICES * 128) + 1;
	localparam int GAIN_W  = 23;
	localparam int PROD_W  = SUM_W + GAIN_W + 1;
	localparam int SCL_W   = PROD_W - 16;
	localparam int MASK_W  = 8;

	localparam logic CFG_VOLUME = 1'b0;
	localparam logic CFG_WIDE   = 1'b1;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_START = 3'd1,
		OP_HALT  = 3'd2,
		OP_QUERY = 3'd3,
		OP_MIX   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_ACC,
		ST_KICK,
		ST_SCALE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                     start;
		logic                     wide;
		logic signed [SUM_W-1:0]  sum;
		logic        [GAIN_W-1:0] gain;
	} scl_req_t;

	function automatic logic [7:0] wide_step(input logic [3:0] v);
		logic [7:0] r;
		unique case (v)
			4'd1:    r = 8'd12;
			4'd2:    r = 8'd19;
			4'd3:    r = 8'd29;
			4'd4:    r = 8'd45;
			4'd5:    r = 8'd70;
			4'd6:    r = 8'd107;
			4'd7:    r = 8'd165;
			4'd8:    r = 8'd255;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [GAIN_W-1:0] gain_q16(input logic [3:0] v, input logic wide);
		logic [GAIN_W-1:0] g;
		if (v == 4'd0 || v > 4'd8) begin
			g = '0;
		end else if (wide) begin
			g = GAIN_W'({wide_step(v), 15'b0});
		end else begin
			g = GAIN_W'(16'd4112 * 16'(v) - 16'd128);
		end
		return g;
	endfunction

endpackage

`default_nettype wire

[rtl/msm_scaler.sv]
// Gain scaling unit: multiply, truncate toward zero, clip to the output range (narrow mode adds 128 first).
// Depends on msm_pkg; used by multichannel_sample_mixer.
`default_nettype none

module msm_scaler import msm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire scl_req_t            req,
	output logic                     done,
	output logic signed [15:0]       sample
);

	localparam logic signed [SCL_W-1:0] WMIN = SCL_W'(-32768);
	localparam logic signed [SCL_W-1:0] WMAX = SCL_W'(32767);
	localparam logic signed [SCL_W-1:0] NMAX = SCL_W'(255);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SCL_W-1:0]  scaled_s2;
	logic                     wide_s1, wide_s2;
	logic                     v_s1, v_s2;
	logic signed [PROD_W-1:0] bias;
	logic signed [SCL_W-1:0]  narrow;
	logic signed [15:0]       clip;

	always_comb begin
		bias   = prod_s1[PROD_W-1] ? $signed({{(PROD_W-16){1'b0}}, 16'hFFFF}) : '0;
		narrow = scaled_s2 + SCL_W'(128);
		if (wide_s2) begin
			priority if (scaled_s2 < WMIN) clip = 16'sh8000;
			else if (scaled_s2 > WMAX)     clip = 16'sh7FFF;
			else                           clip = 16'(scaled_s2);
		end else begin
			priority if (narrow < 0) clip = '0;
			else if (narrow > NMAX)  clip = 16'sd255;
			else                     clip = 16'(narrow);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1   <= PROD_W'(req.sum) * PROD_W'($signed({1'b0, req.gain}));
		wide_s1   <= req.wide;
		scaled_s2 <= SCL_W'((prod_s1 + bias) >>> 16);
		wide_s2   <= wide_s1;
		sample    <= clip;
	end

endmodule

`default_nettype wire

[rtl/multichannel_sample_mixer.sv]
// Top level of the multichannel sample mixer: handshakes, voice state, sample
// store and mix sequencer. Depends on msm_pkg and msm_scaler.
//
//   channel   handshake              payload
//   item      item_valid/item_stall  opcode channel address data_byte sample_length sample_id
//   result    result_valid/stall     mixed_sample finished_mask status id_valid sound_id
//   cfg       cfg_valid/cfg_ready    cfg_index cfg_data
//
// Load, start, halt and query go from idle straight to the finish state; mix takes
// one voice per cycle through the single store read port, then the scaler.
// Reset clears voice state, config and control state; the sample store and the result data registers are not cleared.
// A finished result waits in the output register while the next request enters.
`default_nettype none

module multichannel_sample_mixer import msm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [2:0]         opcode,
	input  wire logic [2:0]         channel,
	input  wire logic [15:0]        address,
	input  wire logic [7:0]         data_byte,
	input  wire logic [15:0]        sample_length,
	input  wire logic [15:0]        sample_id,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [15:0]      mixed_sample,
	output logic [7:0]              finished_mask,
	output logic                    status,
	output logic                    id_valid,
	output logic [15:0]             sound_id,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [3:0]         cfg_data
);

	state_t state_q, state_d;

	logic [7:0]    store [STORE_BYTES];
	logic [7:0]    rd_q;
	logic [SW-1:0] rd_addr;

	logic [15:0] pos_q   [NUM_VOICES];
	logic [15:0] start_q [NUM_VOICES];
	logic [15:0] len_q   [NUM_VOICES];
	logic [15:0] id_q    [NUM_VOICES];
	logic [NUM_VOICES-1:0] active_q;
	logic [NUM_VOICES-1:0] fin_q;

	logic [3:0] volume_q;
	logic       wide_q;

	logic [VW-1:0]           cnt_q;
	logic                    act_s1;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [15:0] res_sample_q;
	logic [7:0]         res_mask_q;
	logic               res_status_q;
	logic               res_idv_q;
	logic [15:0]        res_sid_q;

	logic          accept;
	logic          ch_ok;
	logic [VW-1:0] ch_idx;
	logic [VW-1:0] ridx;
	logic [16:0]   next_pos;
	logic          voice_done;
	logic          out_free;
	logic [7:0]    mask;
	logic          scl_done;
	logic signed [15:0] scl_sample;
	scl_req_t      scl_req;
	op_t           op;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign op         = op_t'(opcode);
	assign ch_ok      = (32'(channel) < 32'(NUM_VOICES));
	assign ch_idx     = VW'(channel);
	assign ridx       = (state_q == ST_MIX) ? cnt_q : ch_idx;
	assign next_pos   = 17'(pos_q[ridx]) + 17'd1;
	assign voice_done = (next_pos >= 17'(len_q[ridx]));
	assign rd_addr    = SW'(17'(start_q[ridx]) + 17'(pos_q[ridx]));
	assign out_free   = !result_valid || !result_stall;

	assign scl_req.start = (state_q == ST_KICK);
	assign scl_req.wide  = wide_q;
	assign scl_req.sum   = sum_q;
	assign scl_req.gain  = gain_q16(volume_q, wide_q);

	for (genvar i = 0; i < MASK_W; i++) begin : g_mask
		if (i < NUM_VOICES) begin : g_on
			assign mask[i] = fin_q[i];
		end else begin : g_off
			assign mask[i] = 1'b0;
		end
	end

	msm_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scl_req),
		.done   (scl_done),
		.sample (scl_sample)
	);

	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD) begin
			store[SW'(address)] <= data_byte;
		end
		rd_q <= store[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (op == OP_MIX) ? ST_MIX : ST_FIN;
				end
			end
			ST_MIX: begin
				if (cnt_q == VW'(NUM_VOICES - 1)) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:   state_d = ST_KICK;
			ST_KICK:  state_d = ST_SCALE;
			ST_SCALE: begin
				if (scl_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= '0;
			wide_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_VOLUME && cfg_data <= 4'd8) begin
				volume_q <= cfg_data;
			end
			if (cfg_index == CFG_WIDE) begin
				wide_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			fin_q    <= '0;
			cnt_q    <= '0;
			act_s1   <= 1'b0;
			sum_q    <= '0;
			for (int i = 0; i < NUM_VOICES; i++) begin
				pos_q[i]   <= '0;
				start_q[i] <= '0;
				len_q[i]   <= '0;
				id_q[i]    <= '0;
			end
		end else begin
			act_s1 <= 1'b0;
			if (act_s1) begin
				sum_q <= sum_q + SUM_W'($signed({~rd_q[7], rd_q[6:0]}));
			end
			if (accept) begin
				cnt_q <= '0;
				fin_q <= '0;
				sum_q <= '0;
				if (op == OP_START && ch_ok) begin
					start_q[ch_idx]  <= address;
					len_q[ch_idx]    <= sample_length;
					id_q[ch_idx]     <= sample_id;
					pos_q[ch_idx]    <= '0;
					active_q[ch_idx] <= 1'b1;
				end
				if (op == OP_HALT && ch_ok) begin
					active_q[ch_idx] <= 1'b0;
				end
			end
			if (state_q == ST_MIX) begin
				cnt_q  <= cnt_q + VW'(1);
				act_s1 <= active_q[cnt_q];
				if (active_q[cnt_q]) begin
					pos_q[cnt_q] <= next_pos[15:0];
					if (voice_done) begin
						active_q[cnt_q] <= 1'b0;
						fin_q[cnt_q]    <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_sample_q <= '0;
			res_mask_q   <= '0;
			res_status_q <= 1'b0;
			res_idv_q    <= 1'b0;
			res_sid_q    <= '0;
			if ((op == OP_START || op == OP_HALT || op == OP_QUERY) && !ch_ok) begin
				res_status_q <= 1'b1;
			end
			if (op == OP_QUERY && ch_ok && active_q[ch_idx]) begin
				res_idv_q <= 1'b1;
				res_sid_q <= id_q[ch_idx];
			end
		end
		if (state_q == ST_KICK) begin
			res_mask_q <= mask;
		end
		if (state_q == ST_SCALE && scl_done) begin
			res_sample_q <= scl_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			mixed_sample  <= res_sample_q;
			finished_mask <= res_mask_q;
			status        <= res_status_q;
			id_valid      <= res_idv_q;
			sound_id      <= res_sid_q;
		end
	end

endmodule

`default_nettype wire
